@@ hw/rtl/atff_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atff_pkg
// Shared constants and types for the ASCII target frame filter.
// ----------------------------------------------------------------------------
package atff_pkg;

    localparam int WINDOW_SIZE   = 10;
    localparam int FILL_BITS     = 4;
    localparam int REJ_BITS      = 4;
    localparam int MEAN_SHIFT    = 3;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;

    localparam int OFF_LIMIT_RESET  = 50;
    localparam int DIST_LIMIT_RESET = 5000;
    localparam int MAX_REJ_RESET    = 1;

    localparam logic [7:0] CH_X     = 8'h58;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_OFFSET = 2'd1,
        PH_DIST   = 2'd2
    } t_phase;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_OFF_LIMIT  = 2'd0,
        CFG_DIST_LIMIT = 2'd1,
        CFG_MAX_REJ    = 2'd2
    } t_cfg_idx;

endpackage

@@ hw/rtl/atff_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atff_parser
// Frame parser: hunts for X, builds saturating decimal offset and distance.
// ----------------------------------------------------------------------------
module atff_parser #(
    parameter int OFFSET_BITS   = 16,
    parameter int DISTANCE_BITS = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_fire,
    input  logic [7:0]               i_byte,
    output logic                     o_frame_end,
    output logic [OFFSET_BITS-1:0]   o_offset,
    output logic [DISTANCE_BITS-1:0] o_distance
);
    import atff_pkg::*;

    localparam int OW = OFFSET_BITS + 4;
    localparam int DW = DISTANCE_BITS + 4;

    t_phase r_phase, n_phase;
    logic [OFFSET_BITS-1:0]   r_off_acc;
    logic [DISTANCE_BITS-1:0] r_dist_acc;

    logic       is_digit;
    logic [3:0] digit;
    logic [OW-1:0] off_x10;
    logic [DW-1:0] dist_x10;
    logic [OFFSET_BITS-1:0]   off_next;
    logic [DISTANCE_BITS-1:0] dist_next;

    assign is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign digit    = 4'(i_byte - CH_ZERO);

    // acc * 10 + digit as two shifts and adds, then saturate
    assign off_x10  = (OW'(r_off_acc) << 3) + (OW'(r_off_acc) << 1) + OW'(digit);
    assign dist_x10 = (DW'(r_dist_acc) << 3) + (DW'(r_dist_acc) << 1) + DW'(digit);
    assign off_next = (off_x10[OW-1:OFFSET_BITS] != '0) ? '1 : off_x10[OFFSET_BITS-1:0];
    assign dist_next = (dist_x10[DW-1:DISTANCE_BITS] != '0) ? '1
                     : dist_x10[DISTANCE_BITS-1:0];

    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_OFFSET: begin
                if (i_byte == CH_S) n_phase = PH_DIST;
            end
            PH_DIST: begin
                if (i_byte == CH_LF) n_phase = PH_HUNT;
            end
            default: begin
                if (i_byte == CH_X) n_phase = PH_OFFSET;
            end
        endcase
    end

    always_comb begin
        o_frame_end = i_fire && (r_phase == PH_DIST) && (i_byte == CH_LF);
        o_offset    = r_off_acc;
        o_distance  = r_dist_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT;
            r_off_acc  <= '0;
            r_dist_acc <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            case (r_phase)
                PH_OFFSET: begin
                    if (i_byte != CH_S && is_digit) r_off_acc <= off_next;
                end
                PH_DIST: begin
                    if (i_byte != CH_LF && is_digit) r_dist_acc <= dist_next;
                end
                default: begin
                    if (i_byte == CH_X) begin
                        r_off_acc  <= '0;
                        r_dist_acc <= '0;
                    end
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/atff_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atff_filter
// Jump limiter and trimmed-mean window over accepted frames.
// ----------------------------------------------------------------------------
module atff_filter #(
    parameter int OFFSET_BITS   = 16,
    parameter int DISTANCE_BITS = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_frame_end,
    input  logic [OFFSET_BITS-1:0]         i_offset,
    input  logic [DISTANCE_BITS-1:0]       i_distance,
    input  logic [OFFSET_BITS-1:0]         i_off_limit,
    input  logic [DISTANCE_BITS-1:0]       i_dist_limit,
    input  logic [atff_pkg::REJ_BITS-1:0]  i_max_rej,
    output logic                           o_res_valid,
    output logic [OFFSET_BITS-1:0]         o_position_x,
    output logic [DISTANCE_BITS-1:0]       o_frame_distance,
    output logic [DISTANCE_BITS-1:0]       o_mean_distance,
    output logic                           o_mean_updated
);
    import atff_pkg::*;

    localparam int SW = DISTANCE_BITS + 4;

    logic [OFFSET_BITS-1:0]   r_last_off;
    logic [DISTANCE_BITS-1:0] r_last_dist;
    logic [REJ_BITS-1:0]      r_off_rej, r_dist_rej;
    logic [FILL_BITS-1:0]     r_fill;
    logic [SW-1:0]            r_sum;
    logic [DISTANCE_BITS-1:0] r_min, r_max, r_mean;

    logic [OFFSET_BITS-1:0]   off_diff;
    logic [DISTANCE_BITS-1:0] dist_diff;
    logic off_drop, dist_drop, accept, close;
    logic [SW-1:0]            sum_new, trimmed;
    logic [DISTANCE_BITS-1:0] min_new, max_new, mean_new;
    logic [FILL_BITS-1:0]     fill_new;

    assign off_diff  = (i_offset > r_last_off) ? i_offset - r_last_off : r_last_off - i_offset;
    assign dist_diff = (i_distance > r_last_dist) ? i_distance - r_last_dist
                     : r_last_dist - i_distance;
    assign off_drop  = (off_diff > i_off_limit) && (r_off_rej < i_max_rej);
    assign dist_drop = (dist_diff > i_dist_limit) && (r_dist_rej < i_max_rej);
    assign accept    = i_frame_end && !off_drop && !dist_drop;

    assign sum_new  = r_sum + SW'(i_distance);
    assign min_new  = (i_distance < r_min) ? i_distance : r_min;
    assign max_new  = (i_distance > r_max) ? i_distance : r_max;
    assign fill_new = r_fill + 1'b1;
    assign close    = (fill_new >= FILL_BITS'(WINDOW_SIZE));
    // sum covers min and max, so this never underflows and fits the field
    assign trimmed  = (sum_new - SW'(min_new) - SW'(max_new)) >> MEAN_SHIFT;
    assign mean_new = trimmed[DISTANCE_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_off  <= '0;
            r_last_dist <= '0;
            r_off_rej   <= '0;
            r_dist_rej  <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_min       <= '1;
            r_max       <= '0;
            r_mean      <= '0;
        end else if (i_frame_end) begin
            if (off_drop) begin
                r_off_rej <= r_off_rej + 1'b1;
            end else begin
                r_off_rej <= '0;
                if (dist_drop) begin
                    r_dist_rej <= r_dist_rej + 1'b1;
                end else begin
                    r_dist_rej  <= '0;
                    r_last_off  <= i_offset;
                    r_last_dist <= i_distance;
                    if (close) begin
                        r_mean <= mean_new;
                        r_fill <= '0;
                        r_sum  <= '0;
                        r_min  <= '1;
                        r_max  <= '0;
                    end else begin
                        r_fill <= fill_new;
                        r_sum  <= sum_new;
                        r_min  <= min_new;
                        r_max  <= max_new;
                    end
                end
            end
        end
    end

    assign o_res_valid      = accept;
    assign o_position_x     = i_offset;
    assign o_frame_distance = i_distance;
    assign o_mean_distance  = close ? mean_new : r_mean;
    assign o_mean_updated   = close;

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < FILL_BITS'(WINDOW_SIZE))
        else $error("window fill out of range");

    a_min_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != '0) |-> (r_min <= r_max))
        else $error("window min above max");

    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && close) |=> (r_fill == '0) && (r_sum == '0))
        else $error("window not cleared after close");

endmodule

@@ hw/rtl/ascii_target_frame_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_target_frame_filter
// Parses X<offset>S<distance>\n frames, rejects jumps, emits trimmed means.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  in      | in        | i_valid / o_stall         | i_rx_byte
//  out     | out       | o_valid / i_stall         | position_x, frame_distance,
//          |           |                           | mean_distance, mean_updated
//  cfg     | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One byte per cycle sustained unless the output stalls; each byte is held in
// the input register, then parser and filter state update as it advances. A
// closing newline loads the result register, so a word passes the input and
// result registers in turn. Bytes that end no accepted frame give no word.
// Synchronous active-low reset restores the default limits and clears state.
// A stall on the output holds the result and backs up into o_stall.
// ----------------------------------------------------------------------------
module ascii_target_frame_filter #(
    parameter int OFFSET_BITS   = 16,
    parameter int DISTANCE_BITS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [7:0]                          i_rx_byte,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [OFFSET_BITS-1:0]              o_position_x,
    output logic [DISTANCE_BITS-1:0]            o_frame_distance,
    output logic [DISTANCE_BITS-1:0]            o_mean_distance,
    output logic                                o_mean_updated,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [atff_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [atff_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import atff_pkg::*;

    logic [OFFSET_BITS-1:0]   r_off_limit;
    logic [DISTANCE_BITS-1:0] r_dist_limit;
    logic [REJ_BITS-1:0]      r_max_rej;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    logic [OFFSET_BITS-1:0]   r_pos;
    logic [DISTANCE_BITS-1:0] r_fdist, r_mean;
    logic       r_upd;

    logic advance, in_take;
    logic frame_end;
    logic [OFFSET_BITS-1:0]   p_offset;
    logic [DISTANCE_BITS-1:0] p_distance;
    logic res_valid, res_upd;
    logic [OFFSET_BITS-1:0]   res_pos;
    logic [DISTANCE_BITS-1:0] res_fdist, res_mean;

    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign in_take = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_limit  <= OFFSET_BITS'(OFF_LIMIT_RESET);
            r_dist_limit <= DISTANCE_BITS'(DIST_LIMIT_RESET);
            r_max_rej    <= REJ_BITS'(MAX_REJ_RESET);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_OFF_LIMIT:  r_off_limit  <= i_cfg_data[OFFSET_BITS-1:0];
                CFG_DIST_LIMIT: r_dist_limit <= i_cfg_data[DISTANCE_BITS-1:0];
                CFG_MAX_REJ:    r_max_rej    <= i_cfg_data[REJ_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) r_in_byte <= i_rx_byte;
    end

    atff_parser #(
        .OFFSET_BITS   (OFFSET_BITS),
        .DISTANCE_BITS (DISTANCE_BITS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (advance),
        .i_byte      (r_in_byte),
        .o_frame_end (frame_end),
        .o_offset    (p_offset),
        .o_distance  (p_distance)
    );

    atff_filter #(
        .OFFSET_BITS   (OFFSET_BITS),
        .DISTANCE_BITS (DISTANCE_BITS)
    ) u_filter (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_frame_end      (frame_end),
        .i_offset         (p_offset),
        .i_distance       (p_distance),
        .i_off_limit      (r_off_limit),
        .i_dist_limit     (r_dist_limit),
        .i_max_rej        (r_max_rej),
        .o_res_valid      (res_valid),
        .o_position_x     (res_pos),
        .o_frame_distance (res_fdist),
        .o_mean_distance  (res_mean),
        .o_mean_updated   (res_upd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_pos   <= res_pos;
            r_fdist <= res_fdist;
            r_mean  <= res_mean;
            r_upd   <= res_upd;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_position_x     = r_pos;
    assign o_frame_distance = r_fdist;
    assign o_mean_distance  = r_mean;
    assign o_mean_updated   = r_upd;

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid && $stable(r_in_byte))
        else $error("held input word lost");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && res_valid) |=> r_out_valid)
        else $error("result word not registered");

    a_res_only_on_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> frame_end)
        else $error("result without frame end");

endmodule
